[src/drt_pkg.sv]
// Package with the shared types and constants of the decaying range tracker.
`timescale 1ns / 1ps
`default_nettype none

package drt_pkg;

    localparam int PRICE_WIDTH_DEF  = 32;
    localparam int DECAY_FRAC_DEF   = 16;

    localparam int ACTION_W         = 2;
    localparam int PRICE_FIELD_W    = 32;
    localparam int RESULT_FIELD_W   = 32;
    localparam int CFG_W            = 16;
    localparam int S_TDATA_W        = 32;
    localparam int S_TUSER_W        = 8;
    localparam int M_TDATA_W        = 96;

    localparam logic [CFG_W-1:0] DECAY_RESET = 16'd62259;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 2'd0,
        ACT_INTERRUPT = 2'd1,
        ACT_RESUME    = 2'd2
    } t_action;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [PRICE_FIELD_W-1:0] price;
        logic                     source_ready;
    } t_item;

    typedef struct packed {
        logic tracking_ready;
        logic paused;
    } t_track;

endpackage

`default_nettype wire

[src/drt_in_reg.sv]
// Input register that holds one accepted word until the update stage takes it.
`timescale 1ns / 1ps
`default_nettype none

module drt_in_reg
    import drt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                 i_advance,
    output logic                      o_s_tready,
    output logic                      o_valid,
    output t_item                     o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_s_tready = !r_valid || i_advance;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.action       <= i_s_tuser[ACTION_W-1:0];
            r_item.price        <= i_s_tdata[PRICE_FIELD_W-1:0];
            r_item.source_ready <= i_s_tuser[ACTION_W];
        end
    end

endmodule

`default_nettype wire

[src/drt_update.sv]
// Next-state logic: envelope compare and decay, pause control and result flag.
`timescale 1ns / 1ps
`default_nettype none

module drt_update
    import drt_pkg::*;
#(
    parameter int PRICE_WIDTH         = PRICE_WIDTH_DEF,
    parameter int DECAY_FRACTION_BITS = DECAY_FRAC_DEF
) (
    input  t_item                       i_item,
    input  t_track                      i_ctrl,
    input  wire logic [PRICE_WIDTH-1:0] i_upper,
    input  wire logic [PRICE_WIDTH-1:0] i_lower,
    input  wire logic [CFG_W-1:0]       i_decay,
    output t_track                      o_ctrl,
    output logic [PRICE_WIDTH-1:0]      o_upper,
    output logic [PRICE_WIDTH-1:0]      o_lower,
    output logic                        o_emit
);

    localparam int PROD_W = PRICE_WIDTH + DECAY_FRACTION_BITS + 1;
    localparam logic [DECAY_FRACTION_BITS:0] ONE_Q = {1'b1, {DECAY_FRACTION_BITS{1'b0}}};

    logic [PRICE_WIDTH-1:0]         price;
    logic [DECAY_FRACTION_BITS-1:0] d;
    logic [DECAY_FRACTION_BITS:0]   w_up;
    logic [DECAY_FRACTION_BITS:0]   w_lo;
    logic [PRICE_WIDTH-1:0]         diff_up;
    logic [PRICE_WIDTH-1:0]         diff_lo;
    logic [PROD_W-1:0]              prod_up;
    logic [PROD_W-1:0]              prod_lo;
    logic [PRICE_WIDTH-1:0]         dec_up;
    logic [PRICE_WIDTH-1:0]         dec_lo;

    assign price   = PRICE_WIDTH'(i_item.price);
    assign d       = DECAY_FRACTION_BITS'(i_decay);
    assign w_up    = {1'b0, d};
    assign w_lo    = ONE_Q - w_up;
    assign diff_up = i_upper - price;
    assign diff_lo = price - i_lower;
    assign prod_up = PROD_W'(diff_up) * PROD_W'(w_up);
    assign prod_lo = PROD_W'(diff_lo) * PROD_W'(w_lo);
    assign dec_up  = price + PRICE_WIDTH'(prod_up >> DECAY_FRACTION_BITS);
    assign dec_lo  = i_lower + PRICE_WIDTH'(prod_lo >> DECAY_FRACTION_BITS);

    always_comb begin
        o_ctrl  = i_ctrl;
        o_upper = i_upper;
        o_lower = i_lower;
        o_emit  = 1'b0;
        case (t_action'(i_item.action))
            ACT_INTERRUPT: begin
                o_ctrl.paused = 1'b1;
            end
            ACT_RESUME: begin
                o_ctrl.paused = 1'b0;
            end
            ACT_TICK: begin
                if (!i_ctrl.tracking_ready) begin
                    // The first usable price seeds both envelopes, even while paused.
                    if (i_item.source_ready) begin
                        o_ctrl.tracking_ready = 1'b1;
                        o_upper               = price;
                        o_lower               = price;
                    end
                end else if (!i_ctrl.paused) begin
                    o_upper = (price > i_upper) ? price : dec_up;
                    o_lower = (price < i_lower) ? price : dec_lo;
                    o_emit  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[src/decaying_range_tracker.sv]
// Top level of the decaying range tracker: state, configuration and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word per clock cycle while the input register can advance; on an
// updating time tick it returns the spread and both envelopes: the word waits in the
// input register while the compare and multiply-add of each envelope settle, and the
// result register and the envelope state take the outcome as the word advances, so the
// next word can follow at once. Interrupt, resume and seeding ticks produce no output
// word. A held output word stalls the input only once the input register is also full.

module decaying_range_tracker
    import drt_pkg::*;
#(
    parameter int PRICE_WIDTH         = PRICE_WIDTH_DEF,
    parameter int DECAY_FRACTION_BITS = DECAY_FRAC_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,  // [31:0] price
    input  wire logic [S_TUSER_W-1:0] i_s_tuser,  // [1:0] action, [2] source_ready
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,  // [31:0] range_value,
                                                  // [63:32] upper_envelope,
                                                  // [95:64] lower_envelope
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]       r_decay;
    logic [PRICE_WIDTH-1:0] r_upper;
    logic [PRICE_WIDTH-1:0] r_lower;
    t_track                 r_ctrl;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data;

    logic [PRICE_WIDTH-1:0] n_upper;
    logic [PRICE_WIDTH-1:0] n_lower;
    t_track                 n_ctrl;
    logic                   emit;
    logic                   in_valid;
    t_item                  in_item;
    logic                   advance;
    logic [PRICE_WIDTH-1:0] spread;

    assign o_cfg_ready = 1'b1;
    assign advance     = in_valid && (!r_out_valid || i_m_tready);
    assign spread      = n_upper - n_lower;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    drt_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_advance  (advance),
        .o_s_tready (o_s_tready),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    drt_update #(
        .PRICE_WIDTH         (PRICE_WIDTH),
        .DECAY_FRACTION_BITS (DECAY_FRACTION_BITS)
    ) u_update (
        .i_item  (in_item),
        .i_ctrl  (r_ctrl),
        .i_upper (r_upper),
        .i_lower (r_lower),
        .i_decay (r_decay),
        .o_ctrl  (n_ctrl),
        .o_upper (n_upper),
        .o_lower (n_lower),
        .o_emit  (emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= DECAY_RESET;
            r_upper     <= '0;
            r_lower     <= '0;
            r_ctrl      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_decay <= i_cfg_data;
            end
            if (advance) begin
                r_upper <= n_upper;
                r_lower <= n_lower;
                r_ctrl  <= n_ctrl;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_data <= {RESULT_FIELD_W'(n_lower), RESULT_FIELD_W'(n_upper),
                           RESULT_FIELD_W'(spread)};
        end
    end

    a_env_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upper >= r_lower)
        else $error("upper envelope fell below lower envelope");

    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.tracking_ready |=> r_ctrl.tracking_ready)
        else $error("tracking ready flag cleared without reset");

    a_out_after_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_ctrl.tracking_ready)
        else $error("result word before envelopes were seeded");

    a_out_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:0] == o_m_tdata[63:32] - o_m_tdata[95:64]))
        else $error("result spread does not match envelopes");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_valid |-> o_s_tready)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
